>>> sv/tlrs_pkg.sv
// Shared types, widths and helpers for the threshold life row stencil.
// No dependencies; every other file imports this package.
package tlrs_pkg;

  localparam int ROW_W   = 64;
  localparam int CNT_W   = 7;
  localparam int TOTAL_W = 17;
  localparam int THR_W   = 4;
  localparam int COLS_W  = 7;
  localparam int NBR_W   = 4;   // holds a neighbor count 0..8
  localparam int PART_N  = ROW_W / 8;

  localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = {TOTAL_W{1'b1}};

  // register select on paddr[2]
  localparam logic REG_THRESH = 1'b0;
  localparam logic REG_COLS   = 1'b1;

  localparam logic [THR_W-1:0]  THRESH_RST = 4'd3;
  localparam logic [COLS_W-1:0] COLS_RST   = 7'd64;

  // column bits a cell shows its neighbors: row above, middle row, incoming row
  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } nbr_t;

  // per-beat control broadcast to every cell
  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic             take;
    logic             last;
  } cell_ctl_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage

>>> sv/tlrs_cell.sv
// One column cell: holds this column's bits of the two stored rows and
// computes the column's next-generation bits. Depends on tlrs_pkg.
module tlrs_cell import tlrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      col_en,
  input  logic      in_bit,
  input  nbr_t      left,
  input  nbr_t      right,
  output nbr_t      own,
  output logic      res_a,
  output logic      res_b
);

  logic             above;
  logic             middle;
  logic [NBR_W-1:0] cnt_a;
  logic [NBR_W-1:0] cnt_b;

  assign own.up  = above  & col_en;
  assign own.mid = middle & col_en;
  assign own.dn  = in_bit & col_en;

  // row above / middle / incoming around this column
  assign cnt_a = NBR_W'(left.up)  + NBR_W'(own.up)  + NBR_W'(right.up)
               + NBR_W'(left.mid) + NBR_W'(right.mid)
               + NBR_W'(left.dn)  + NBR_W'(own.dn)  + NBR_W'(right.dn);

  // last row: middle moves up, incoming is the middle, dead row below
  assign cnt_b = NBR_W'(left.mid) + NBR_W'(own.mid) + NBR_W'(right.mid)
               + NBR_W'(left.dn)  + NBR_W'(right.dn);

  // the middle row moves up as stored; the width in force masks it at use
  always_ff @(posedge clk) begin
    if (rst) begin
      above  <= 1'b0;
      middle <= 1'b0;
    end else if (ctl.take) begin
      above  <= ctl.last ? 1'b0 : middle;
      middle <= ctl.last ? 1'b0 : own.dn;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      res_a <= col_en & (cnt_a >= ctl.thr);
      res_b <= col_en & (cnt_b >= ctl.thr);
    end
  end

endmodule

>>> sv/tlrs_tally.sv
// Two-stage result tally: byte popcounts, then row count, saturating frame
// total and the output register. Depends on tlrs_pkg.
module tlrs_tally import tlrs_pkg::*; #(
  parameter int FRAME_CAP = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ROW_W-1:0]   in_row,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ROW_W-1:0]   out_row,
  output logic [CNT_W-1:0]   out_count,
  output logic [TOTAL_W-1:0] out_total,
  output logic               out_last
);

  localparam logic [TOTAL_W:0] CAP = (TOTAL_W+1)'(FRAME_CAP);

  logic               s1_valid;
  logic [ROW_W-1:0]   s1_row;
  logic               s1_last;
  logic [3:0]         s1_part [PART_N];
  logic               s2_load;
  logic [CNT_W-1:0]   row_cnt;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;

  assign s2_load  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_row  <= in_row;
      s1_last <= in_last;
      for (int k = 0; k < PART_N; k++) begin
        s1_part[k] <= pop8(in_row[8*k +: 8]);
      end
    end
  end

  always_comb begin
    row_cnt = '0;
    for (int k = 0; k < PART_N; k++) begin
      row_cnt = row_cnt + CNT_W'(s1_part[k]);
    end
    sum        = {1'b0, total} + (TOTAL_W+1)'(row_cnt);
    total_next = (sum > CAP) ? CAP[TOTAL_W-1:0] : sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      total     <= '0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        total <= s1_last ? '0 : total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      out_row   <= s1_row;
      out_count <= row_cnt;
      out_total <= total_next;
      out_last  <= s1_last;
    end
  end

endmodule

>>> sv/threshold_life_row_stencil.sv
// Top level of the threshold life row stencil: column cell chain, result
// staging, tally pipeline and APB registers. Depends on tlrs_pkg, tlrs_cell, tlrs_tally.
//
// Streams one grid row per input beat (bit c = column c) and returns rows of
// the next generation: a cell lives when at least live_threshold of its eight
// neighbors live; its own state is ignored and cells off the grid are dead.
// A row's result leaves once the row below it has arrived; the beat flagged
// tlast also flushes its own row against a dead row below, then the frame
// restarts. Results carry the row's live count and a frame total that
// saturates at min(MAX_COLS*MAX_ROWS, 131071). Rate: one input beat per
// cycle while each beat yields at most one result and the output is not
// stalled; the last row of a frame (after the first) yields two results and
// holds the input while both are staged, since the output side moves one
// beat per cycle at most. Results are registered in the cells, then in both
// tally stages. A row of MAX_COLS column cells holds the two stored rows;
// each cell exchanges its bits with both neighbors every cycle. Registers
// (APB, write when idle): 0x0 live_threshold (4 bits, reset 3), 0x4
// active_cols (7 bits, reset 64, values above MAX_COLS act as MAX_COLS).
module threshold_life_row_stencil import tlrs_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] row_bits
  input  logic        s_tlast,   // last_row
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [63:0] next_row, [70:64] row_live_count,
                                 // [87:71] frame_live_total
  output logic        m_tlast    // last_of_frame
);

  localparam int FRAME_PRODUCT = MAX_COLS * MAX_ROWS;
  localparam int FRAME_CAP = (FRAME_PRODUCT > int'(TOTAL_LIMIT)) ? int'(TOTAL_LIMIT)
                                                                  : FRAME_PRODUCT;

  logic [THR_W-1:0]  live_threshold;
  logic [COLS_W-1:0] active_cols;
  logic [COLS_W-1:0] eff_cols;
  logic              cfg_wr;

  logic              take;
  logic              mid_valid;
  logic              pend_a;   // result for the middle row waits
  logic              pend_b;   // flush result for the last row waits
  logic              pop;
  logic              tally_ready;
  logic [ROW_W-1:0]  row_a;
  logic [ROW_W-1:0]  row_b;
  cell_ctl_t         ctl;
  nbr_t              nbr [ROW_W];

  logic [ROW_W-1:0]   out_row;
  logic [CNT_W-1:0]   out_count;
  logic [TOTAL_W-1:0] out_total;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_threshold <= THRESH_RST;
      active_cols    <= COLS_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_THRESH: live_threshold <= pwdata[THR_W-1:0];
        REG_COLS:   active_cols    <= pwdata[COLS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESH: prdata = {{(32-THR_W){1'b0}}, live_threshold};
      REG_COLS:   prdata = {{(32-COLS_W){1'b0}}, active_cols};
      default:    prdata = '0;
    endcase
  end

  assign eff_cols = (active_cols > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : active_cols;

  // ------------------------------------------------------------- handshake
  // Staging holds up to two results; take a beat when it is empty or its one result drains this cycle.
  assign pop      = (pend_a || pend_b) && tally_ready;
  assign s_tready = (!pend_a && !pend_b) || ((pend_a ^ pend_b) && pop);
  assign take     = s_tvalid && s_tready;

  assign ctl.thr  = live_threshold;
  assign ctl.take = take;
  assign ctl.last = s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      pend_a    <= 1'b0;
      pend_b    <= 1'b0;
    end else if (take) begin
      mid_valid <= !s_tlast;
      pend_a    <= mid_valid;
      pend_b    <= s_tlast;
    end else if (pop) begin
      if (pend_a) begin
        pend_a <= 1'b0;
      end else begin
        pend_b <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ cell chain
  for (genvar c = 0; c < ROW_W; c++) begin : g_col
    if (c < MAX_COLS) begin : g_cell
      nbr_t left_n;
      nbr_t right_n;
      if (c == 0) begin : g_l0
        assign left_n = '0;
      end else begin : g_ln
        assign left_n = nbr[c-1];
      end
      if (c == MAX_COLS - 1) begin : g_r0
        assign right_n = '0;
      end else begin : g_rn
        assign right_n = nbr[c+1];
      end
      tlrs_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .col_en (COLS_W'(c) < eff_cols),
        .in_bit (s_tdata[c]),
        .left   (left_n),
        .right  (right_n),
        .own    (nbr[c]),
        .res_a  (row_a[c]),
        .res_b  (row_b[c])
      );
    end else begin : g_dead
      assign nbr[c]   = '0;
      assign row_a[c] = 1'b0;
      assign row_b[c] = 1'b0;
    end
  end

  // ----------------------------------------------------------------- tally
  tlrs_tally #(
    .FRAME_CAP (FRAME_CAP)
  ) u_tally (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pend_a || pend_b),
    .in_ready  (tally_ready),
    .in_row    (pend_a ? row_a : row_b),
    .in_last   (!pend_a),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_count (out_count),
    .out_total (out_total),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_total, out_count, out_row};

  // ------------------------------------------------------------ assertions
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (pend_a && pend_b) |-> !s_tready)
    else $error("input taken while two results staged");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (take && s_tlast) |=> (!mid_valid && pend_b))
    else $error("last row did not flush and restart the frame");

  a_middle_result: assert property (@(posedge clk) disable iff (rst)
    (take && mid_valid) |=> pend_a)
    else $error("middle row result lost");

  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, out_total} <= (TOTAL_W+1)'(FRAME_CAP)))
    else $error("frame total above cap");

endmodule
